// ----- hdl/spk_pkg.sv -----
package spk_pkg;

  typedef enum logic [2:0] {
    OP_DENSITY  = 3'd0,
    OP_PRESSURE = 3'd1,
    OP_VISC     = 3'd2,
    OP_NORMAL   = 3'd3,
    OP_SURFACE  = 3'd4,
    OP_WALL     = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_RANGE = 2'd1,
    STS_DIVZ  = 2'd2
  } sts_e;

  typedef enum logic [2:0] {
    REG_FLUID_MASS  = 3'd0,
    REG_WALL_MASS   = 3'd1,
    REG_RHO_SCALE   = 3'd2,
    REG_PRESS_SCALE = 3'd3,
    REG_VIS_SCALE   = 3'd4,
    REG_NORM_SCALE  = 3'd5,
    REG_SUR_SCALE   = 3'd6
  } reg_e;

  typedef enum logic [1:0] {
    SH0  = 2'd0,
    SH16 = 2'd1,
    SH24 = 2'd2,
    SH32 = 2'd3
  } sh_e;

  localparam int unsigned PADDR_W = 6;

  localparam logic [63:0] ALL1  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ONE32 = 64'h0000_0001_0000_0000;
  localparam logic [63:0] A3    = 64'h0000_0003_0000_0000;
  localparam logic [63:0] TOP   = 64'h8000_0000_0000_0000;

  // pipeline map
  localparam int unsigned RT_N     = 16;  // square root, two bits a stage
  localparam int unsigned DV_N     = 64;  // dividers, two quotient bits a stage
  localparam int unsigned DV_STEPS = 128 / DV_N;
  localparam int unsigned RT_STEPS = 32 / RT_N;
  localparam int unsigned ST_IN    = 0;
  localparam int unsigned ST_SQ    = 1;
  localparam int unsigned ST_D2    = 2;
  localparam int unsigned ST_CLS   = 3;
  localparam int unsigned ST_RT0   = 4;
  localparam int unsigned ST_PREP  = ST_RT0 + RT_N;
  localparam int unsigned ST_MUL1  = ST_PREP + 1;
  localparam int unsigned ST_MUL2  = ST_MUL1 + 2;
  localparam int unsigned ST_MUL3  = ST_MUL2 + 2;
  localparam int unsigned ST_MUL4  = ST_MUL3 + 2;
  localparam int unsigned ST_DI    = ST_MUL4 + 2;
  localparam int unsigned ST_DV0   = ST_DI + 1;
  localparam int unsigned ST_POST  = ST_DV0 + DV_N;
  localparam int unsigned ST_MUL5  = ST_POST + 1;
  localparam int unsigned ST_MUL6  = ST_MUL5 + 2;
  localparam int unsigned ST_OUT   = ST_MUL6 + 2;
  localparam int unsigned NSTG     = ST_OUT + 1;

  typedef struct packed {
    logic [31:0] fluid_mass;
    logic [31:0] wall_mass;
    logic [47:0] rho_scale;
    logic [47:0] press_scale;
    logic [47:0] vis_scale;
    logic [47:0] norm_scale;
    logic [47:0] sur_scale;
  } cfg_t;

  typedef struct packed {
    logic [63:0]  rem;
    logic [127:0] n;    // dividend shifting out, quotient shifting in
    logic [63:0]  den;
    logic         nz;
  } dlane_t;

  typedef struct packed {
    logic [2:0]       op;
    logic             fluid;
    logic             nba;
    logic             npa;
    logic             npb;
    logic             neg;
    logic             beyond;
    logic             zero;
    logic             divz;
    logic             dact;
    logic [31:0]      mx;
    logic [31:0]      my;
    logic [31:0]      mz;
    logic [31:0]      mba;
    logic [31:0]      rhoa;
    logic [31:0]      rhob;
    logic [47:0]      mpa;
    logic [47:0]      mpb;
    logic [63:0]      sqx;
    logic [63:0]      sqy;
    logic [63:0]      sqz;
    logic [63:0]      w2;
    logic [63:0]      rhoa2;
    logic [63:0]      rhob2;
    logic [63:0]      d2;
    logic [32:0]      u;
    logic [63:0]      t;
    logic [63:0]      sv;
    logic [63:0]      sr;
    logic [31:0]      r;
    logic [63:0]      g;
    logic [63:0]      pc;
    logic [63:0]      p0;
    logic [63:0]      p1;
    logic [63:0]      p2;
    logic [63:0]      p3;
    sh_e              sh;
    dlane_t [2:0]     lane;
    logic [1:0]       sts;
  } item_t;

  function automatic item_t f_sq(item_t it);
    item_t o;
    o       = it;
    o.sqx   = it.mx * it.mx;
    o.sqy   = it.my * it.my;
    o.sqz   = it.mz * it.mz;
    o.w2    = it.mba * it.mba;
    o.rhoa2 = it.rhoa * it.rhoa;
    o.rhob2 = it.rhob * it.rhob;
    return o;
  endfunction

  function automatic item_t f_d2(item_t it);
    item_t o;
    o    = it;
    o.d2 = it.sqx + it.sqy + it.sqz;
    // wall distance term |1 - riw^2|
    o.t  = (it.w2 > ONE32) ? (it.w2 - ONE32) : (ONE32 - it.w2);
    return o;
  endfunction

  function automatic item_t f_cls(item_t it);
    item_t       o;
    logic [63:0] b7;
    logic        nt;
    o        = it;
    b7       = (it.d2 << 3) - it.d2;
    nt       = b7 > A3;
    o.beyond = (it.op <= OP_SURFACE) && (it.d2 > ONE32);
    o.u      = 33'h1_0000_0000 - it.d2[32:0];
    o.zero   = ((it.op == OP_VISC) && (it.d2 == 64'd0)) || (it.op > OP_WALL);
    if (it.op == OP_NORMAL) begin
      o.t = nt ? (b7 - A3) : (A3 - b7);
    end
    case (it.op)
      OP_VISC:    o.neg = it.nba;
      OP_NORMAL:  o.neg = (nt == it.nba);
      OP_SURFACE: o.neg = 1'b1;
      default:    o.neg = 1'b0;
    endcase
    o.sv = it.d2;
    o.sr = 64'd0;
    return o;
  endfunction

  function automatic item_t f_rt(item_t it, int unsigned j);
    item_t       o;
    logic [63:0] bitv;
    o = it;
    for (int unsigned e = 0; e < RT_STEPS; e++) begin
      bitv = 64'd1 << (62 - 2 * (RT_STEPS * j + e));
      if (o.sv >= o.sr + bitv) begin
        o.sv = o.sv - (o.sr + bitv);
        o.sr = (o.sr >> 1) + bitv;
      end else begin
        o.sr = o.sr >> 1;
      end
    end
    return o;
  endfunction

  function automatic item_t f_prep(item_t it);
    item_t       o;
    logic [16:0] t17;
    logic [33:0] tt;
    o   = it;
    o.r = it.sr[31:0];
    t17 = 17'h1_0000 - it.sr[16:0];
    tt  = t17 * t17;
    if (it.op == OP_PRESSURE) begin
      o.t = {30'd0, tt};
    end else if (it.op == OP_VISC) begin
      o.t = {47'd0, t17};
    end
    return o;
  endfunction

  function automatic item_t f_mula(int unsigned slot, item_t it, cfg_t c);
    item_t       o;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] m;
    sh_e         sh;
    o  = it;
    m  = {32'd0, it.fluid ? c.fluid_mass : c.wall_mass};
    a  = it.g;
    b  = 64'd1;
    sh = SH0;
    case (slot)
      1: begin
        case (it.op)
          OP_DENSITY, OP_SURFACE: begin a = {31'd0, it.u}; b = {31'd0, it.u}; sh = SH32; end
          OP_WALL:     begin a = it.t; b = it.t; sh = SH32; end
          OP_NORMAL:   begin a = {16'd0, c.norm_scale}; b = {31'd0, it.u}; sh = SH32; end
          OP_VISC:     begin a = {16'd0, c.vis_scale}; b = it.t; sh = SH16; end
          OP_PRESSURE: begin a = {16'd0, c.press_scale}; b = it.t; sh = SH32; end
          default: ;
        endcase
      end
      2: begin
        case (it.op)
          OP_DENSITY:  begin b = {31'd0, it.u}; sh = SH32; end
          OP_WALL, OP_NORMAL: begin b = it.t; sh = SH32; end
          OP_SURFACE:  begin a = {16'd0, c.sur_scale}; b = it.g; sh = SH32; end
          OP_VISC, OP_PRESSURE: begin b = {32'd0, it.mba}; sh = SH16; end
          default: ;
        endcase
      end
      3: begin
        case (it.op)
          OP_DENSITY, OP_WALL: begin a = {16'd0, c.rho_scale}; b = it.g; sh = SH32; end
          OP_SURFACE, OP_VISC: begin a = m; b = it.g; sh = SH24; end
          OP_NORMAL:   begin b = {32'd0, it.mba}; sh = SH16; end
          default: ;
        endcase
      end
      4: begin
        case (it.op)
          OP_DENSITY, OP_NORMAL: begin a = m; b = it.g; sh = SH24; end
          OP_WALL:     begin a = {32'd0, c.wall_mass}; b = it.g; sh = SH24; end
          default: ;
        endcase
      end
      5: begin
        if (it.op == OP_PRESSURE) begin
          a = m; b = it.g; sh = SH24;
        end
      end
      default: begin
        if (it.op == OP_PRESSURE) begin
          b = it.pc; sh = SH24;
        end
      end
    endcase
    o.p0 = a[31:0] * b[31:0];
    o.p1 = a[31:0] * b[63:32];
    o.p2 = a[63:32] * b[31:0];
    o.p3 = a[63:32] * b[63:32];
    o.sh = sh;
    return o;
  endfunction

  function automatic item_t f_mulb(item_t it);
    item_t       o;
    logic [33:0] mid;
    logic [63:0] lo;
    logic [63:0] hi;
    o   = it;
    mid = {2'd0, it.p0[63:32]} + {2'd0, it.p1[31:0]} + {2'd0, it.p2[31:0]};
    lo  = {mid[31:0], it.p0[31:0]};
    hi  = it.p3 + {32'd0, it.p1[63:32]} + {32'd0, it.p2[63:32]} + {62'd0, mid[33:32]};
    case (it.sh)
      SH0:     o.g = (hi != 64'd0) ? ALL1 : lo;
      SH16:    o.g = (hi[63:16] != 48'd0) ? ALL1 : {hi[15:0], lo[63:16]};
      SH24:    o.g = (hi[63:24] != 40'd0) ? ALL1 : {hi[23:0], lo[63:24]};
      default: o.g = (hi[63:32] != 32'd0) ? ALL1 : {hi[31:0], lo[63:32]};
    endcase
    return o;
  endfunction

  function automatic item_t f_di(item_t it);
    item_t o;
    o      = it;
    o.dact = !it.beyond && !it.zero &&
             ((it.op == OP_PRESSURE) || (it.op == OP_VISC) ||
              (it.op == OP_NORMAL) || (it.op == OP_SURFACE));
    o.lane[0].rem = 64'd0;
    o.lane[0].n   = {48'd0, it.g, 16'd0};
    o.lane[0].den = (it.op == OP_PRESSURE) ? {32'd0, it.r} : {32'd0, it.rhob};
    o.lane[0].nz  = it.g != 64'd0;
    o.lane[1].rem = 64'd0;
    o.lane[1].n   = {40'd0, it.mpa, 40'd0};
    o.lane[1].den = it.rhoa2;
    o.lane[1].nz  = it.mpa != 48'd0;
    o.lane[2].rem = 64'd0;
    o.lane[2].n   = {40'd0, it.mpb, 40'd0};
    o.lane[2].den = it.rhob2;
    o.lane[2].nz  = it.mpb != 48'd0;
    return o;
  endfunction

  function automatic item_t f_dv(item_t it);
    item_t       o;
    logic        carry;
    logic [63:0] rs;
    o = it;
    for (int unsigned l = 0; l < 3; l++) begin
      for (int unsigned e = 0; e < DV_STEPS; e++) begin
        carry     = o.lane[l].rem[63];
        rs        = {o.lane[l].rem[62:0], o.lane[l].n[127]};
        o.lane[l].n = {o.lane[l].n[126:0], 1'b0};
        if (carry || (rs >= o.lane[l].den)) begin
          o.lane[l].rem  = rs - o.lane[l].den;
          o.lane[l].n[0] = 1'b1;
        end else begin
          o.lane[l].rem = rs;
        end
      end
    end
    return o;
  endfunction

  function automatic logic [63:0] clampq(dlane_t ln);
    logic [63:0] q;
    if (ln.den == 64'd0) begin
      q = ln.nz ? ALL1 : 64'd0;
    end else begin
      q = (ln.n[127:64] != 64'd0) ? ALL1 : ln.n[63:0];
    end
    return q;
  endfunction

  function automatic item_t f_post(item_t it);
    item_t       o;
    logic [63:0] ta;
    logic [63:0] tb;
    logic        npc;
    o  = it;
    ta = clampq(it.lane[1]);
    tb = clampq(it.lane[2]);
    if (it.dact) begin
      o.g    = clampq(it.lane[0]);
      o.divz = (it.lane[0].den == 64'd0) ||
               ((it.op == OP_PRESSURE) &&
                ((it.lane[1].den == 64'd0) || (it.lane[2].den == 64'd0)));
    end else begin
      o.divz = 1'b0;
    end
    if (it.npa == it.npb) begin
      o.pc = (ta > ALL1 - tb) ? ALL1 : ta + tb;
      npc  = it.npa;
    end else if (ta >= tb) begin
      o.pc = ta - tb;
      npc  = it.npa;
    end else begin
      o.pc = tb - ta;
      npc  = it.npb;
    end
    if (it.op == OP_PRESSURE) begin
      o.neg = it.nba != npc;
    end
    return o;
  endfunction

  function automatic item_t f_out(item_t it);
    item_t o;
    o = it;
    if (it.beyond) begin
      o.g   = 64'd0;
      o.sts = STS_RANGE;
    end else if (it.zero) begin
      o.g   = 64'd0;
      o.sts = STS_OK;
    end else begin
      if (it.neg) begin
        o.g = (it.g >= TOP) ? TOP : (64'd0 - it.g);
      end else begin
        o.g = (it.g >= TOP) ? (TOP - 64'd1) : it.g;
      end
      o.sts = it.divz ? STS_DIVZ : STS_OK;
    end
    return o;
  endfunction

endpackage

// ----- hdl/sph_pair_kernel_unit.sv -----
// SPH pair kernel unit: one particle-pair kernel contribution per request, fully
// pipelined. A request accepted on the input channel shows its result on the output
// channel after passing every stage; a new request can be taken every cycle, and the
// whole pipeline holds while a finished result waits on out_ready_i. The depth comes
// mostly from the 16-stage square root (two root bits a stage) and the 64-stage
// dividers (two quotient bits a stage) that sit in series with six split 64x64
// multipliers. Scale and mass registers are on the APB port at byte offsets 8*index,
// 64-bit data, and must only be written while no request is in flight.
module sph_pair_kernel_unit import spk_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           opcode_i,
  input  logic signed [31:0]   dx_i,
  input  logic signed [31:0]   dy_i,
  input  logic signed [31:0]   dz_i,
  input  logic signed [31:0]   axis_delta_i,
  input  logic [31:0]          a_density_i,
  input  logic signed [47:0]   a_pressure_i,
  input  logic [31:0]          b_density_i,
  input  logic signed [47:0]   b_pressure_i,
  input  logic                 b_is_fluid_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [63:0]   contribution_o,
  output logic [1:0]           status_o
);

  cfg_t            cfg_q;
  logic [NSTG-1:0] vld_q;
  item_t           stg_q [NSTG];
  item_t           nxt   [NSTG];
  logic            adv;
  logic            wr_en;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (paddr[PADDR_W-1:3])
        REG_FLUID_MASS:  cfg_q.fluid_mass  <= pwdata[31:0];
        REG_WALL_MASS:   cfg_q.wall_mass   <= pwdata[31:0];
        REG_RHO_SCALE:   cfg_q.rho_scale   <= pwdata[47:0];
        REG_PRESS_SCALE: cfg_q.press_scale <= pwdata[47:0];
        REG_VIS_SCALE:   cfg_q.vis_scale   <= pwdata[47:0];
        REG_NORM_SCALE:  cfg_q.norm_scale  <= pwdata[47:0];
        REG_SUR_SCALE:   cfg_q.sur_scale   <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[PADDR_W-1:3])
      REG_FLUID_MASS:  prdata = {32'd0, cfg_q.fluid_mass};
      REG_WALL_MASS:   prdata = {32'd0, cfg_q.wall_mass};
      REG_RHO_SCALE:   prdata = {16'd0, cfg_q.rho_scale};
      REG_PRESS_SCALE: prdata = {16'd0, cfg_q.press_scale};
      REG_VIS_SCALE:   prdata = {16'd0, cfg_q.vis_scale};
      REG_NORM_SCALE:  prdata = {16'd0, cfg_q.norm_scale};
      REG_SUR_SCALE:   prdata = {16'd0, cfg_q.sur_scale};
      default:         prdata = 64'd0;
    endcase
  end

  // ---------------- pipeline control ----------------
  // global advance: the pipe moves unless the output holds an unaccepted result
  assign adv        = !vld_q[NSTG-1] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTG-2:0], in_valid_i};
    end
  end

  // ---------------- input stage: sign-magnitude split ----------------
  always_comb begin
    nxt[ST_IN]       = '0;
    nxt[ST_IN].op    = opcode_i;
    nxt[ST_IN].fluid = b_is_fluid_i;
    nxt[ST_IN].mx    = dx_i[31] ? (32'd0 - dx_i) : dx_i;
    nxt[ST_IN].my    = dy_i[31] ? (32'd0 - dy_i) : dy_i;
    nxt[ST_IN].mz    = dz_i[31] ? (32'd0 - dz_i) : dz_i;
    nxt[ST_IN].nba   = axis_delta_i[31];
    nxt[ST_IN].mba   = axis_delta_i[31] ? (32'd0 - axis_delta_i) : axis_delta_i;
    nxt[ST_IN].rhoa  = a_density_i;
    nxt[ST_IN].rhob  = b_density_i;
    nxt[ST_IN].npa   = a_pressure_i[47];
    nxt[ST_IN].mpa   = a_pressure_i[47] ? (48'd0 - a_pressure_i) : a_pressure_i;
    nxt[ST_IN].npb   = b_pressure_i[47];
    nxt[ST_IN].mpb   = b_pressure_i[47] ? (48'd0 - b_pressure_i) : b_pressure_i;
  end

  // ---------------- datapath stages ----------------
  for (genvar k = 1; k < NSTG; k++) begin : g_stage
    if (k == ST_SQ) begin : g_sq
      assign nxt[k] = f_sq(stg_q[k-1]);
    end else if (k == ST_D2) begin : g_d2
      assign nxt[k] = f_d2(stg_q[k-1]);
    end else if (k == ST_CLS) begin : g_cls
      assign nxt[k] = f_cls(stg_q[k-1]);
    end else if (k >= ST_RT0 && k < ST_PREP) begin : g_rt
      assign nxt[k] = f_rt(stg_q[k-1], k - ST_RT0);
    end else if (k == ST_PREP) begin : g_prep
      assign nxt[k] = f_prep(stg_q[k-1]);
    end else if (k == ST_MUL1) begin : g_m1
      assign nxt[k] = f_mula(1, stg_q[k-1], cfg_q);
    end else if (k == ST_MUL2) begin : g_m2
      assign nxt[k] = f_mula(2, stg_q[k-1], cfg_q);
    end else if (k == ST_MUL3) begin : g_m3
      assign nxt[k] = f_mula(3, stg_q[k-1], cfg_q);
    end else if (k == ST_MUL4) begin : g_m4
      assign nxt[k] = f_mula(4, stg_q[k-1], cfg_q);
    end else if (k == ST_MUL5) begin : g_m5
      assign nxt[k] = f_mula(5, stg_q[k-1], cfg_q);
    end else if (k == ST_MUL6) begin : g_m6
      assign nxt[k] = f_mula(6, stg_q[k-1], cfg_q);
    end else if (k == ST_MUL1 + 1 || k == ST_MUL2 + 1 || k == ST_MUL3 + 1 ||
                 k == ST_MUL4 + 1 || k == ST_MUL5 + 1 || k == ST_MUL6 + 1) begin : g_mb
      assign nxt[k] = f_mulb(stg_q[k-1]);
    end else if (k == ST_DI) begin : g_di
      assign nxt[k] = f_di(stg_q[k-1]);
    end else if (k >= ST_DV0 && k < ST_POST) begin : g_dv
      assign nxt[k] = f_dv(stg_q[k-1]);
    end else if (k == ST_POST) begin : g_post
      assign nxt[k] = f_post(stg_q[k-1]);
    end else begin : g_out
      assign nxt[k] = f_out(stg_q[k-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int unsigned k = 0; k < NSTG; k++) begin
        stg_q[k] <= nxt[k];
      end
    end
  end

  assign out_valid_o    = vld_q[NSTG-1];
  assign contribution_o = stg_q[ST_OUT].g;
  assign status_o       = stg_q[ST_OUT].sts;

endmodule
